// File: sv/pmcr_pkg.sv
// Shared types and constants for the post-mortem capture ring.
package pmcr_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;
    localparam int COUNT_BITS_DEF   = 48;
    localparam int LEN_BITS         = 11;
    localparam int IDX_BITS         = 10;
    localparam int ADDR_BITS        = 20;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [63:0] TS_INVALID = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_FREEZE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_OUTSIDE = 2'd2
    } kind_e;

    typedef struct packed {
        logic [1:0]          command;
        logic [31:0]         sample_value;
        logic [31:0]         sample_error;
        logic                tag_present;
        logic signed [63:0]  tag_timestamp;
        logic [31:0]         tag_period;
        logic [LEN_BITS-1:0] read_count;
        logic [IDX_BITS-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        kind_e               kind;
        logic [31:0]         out_value;
        logic [31:0]         out_error;
        logic signed [63:0]  window_timestamp;
        logic [LEN_BITS-1:0] window_length;
    } out_item_t;

    // Op passed from the front end to the back end
    typedef struct packed {
        kind_e                kind;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          value;
        logic [31:0]          error;
        logic                 rd_zero;
        logic [LEN_BITS-1:0]  n;
        logic [63:0]          seen;
        logic [63:0]          tag_pos;
        logic [63:0]          tag_time;
        logic [31:0]          tag_period;
    } q_entry_t;

endpackage

// File: sv/pmcr_front.sv
// Front end: accepts transactions, keeps ring pointers, counters and tag, builds ops.
module pmcr_front #(
    parameter int BUFFER_DEPTH = pmcr_pkg::BUFFER_DEPTH_DEF,
    parameter int COUNT_BITS   = pmcr_pkg::COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pmcr_pkg::in_item_t s_data,
    input  logic               q_full,
    output logic               q_push,
    output pmcr_pkg::q_entry_t q_entry
);
    import pmcr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = ((AW > LEN_BITS) ? AW : LEN_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [AW-1:0]         wp_reg, wp_next;
    logic                  wrapped_reg, wrapped_next;
    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic                  frozen_reg, frozen_next;
    logic [63:0]           tag_time_reg, tag_time_next;
    logic [COUNT_BITS-1:0] tag_pos_reg, tag_pos_next;
    logic [31:0]           tag_period_reg, tag_period_next;

    logic                accept;
    logic [LEN_BITS-1:0] n_seen;
    logic [LEN_BITS-1:0] n;
    logic [LEN_BITS-1:0] back_dist;
    logic                in_win;
    logic [CW-1:0]       wpx;
    logic [CW-1:0]       bx;
    logic                no_wrap;
    logic [CW-1:0]       pos_x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            seen_reg       <= '0;
            frozen_reg     <= 1'b0;
            tag_time_reg   <= TS_INVALID;
            tag_pos_reg    <= '0;
            tag_period_reg <= '0;
        end else begin
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            seen_reg       <= seen_next;
            frozen_reg     <= frozen_next;
            tag_time_reg   <= tag_time_next;
            tag_pos_reg    <= tag_pos_next;
            tag_period_reg <= tag_period_next;
        end
    end

    always_comb begin
        s_ready = !q_full;
        accept  = s_valid && s_ready;

        // window length: min(read_count, samples seen, depth)
        n_seen = (COUNT_BITS'(s_data.read_count) > seen_reg) ? LEN_BITS'(seen_reg)
                                                              : s_data.read_count;
        n = (32'(n_seen) > 32'(BUFFER_DEPTH)) ? LEN_BITS'(BUFFER_DEPTH) : n_seen;
        in_win    = LEN_BITS'(s_data.entry_index) < n;
        back_dist = n - LEN_BITS'(s_data.entry_index);

        // ring position = wp - (n - idx), modulo depth
        wpx     = CW'(wp_reg);
        bx      = CW'(back_dist);
        no_wrap = wpx >= bx;
        pos_x   = no_wrap ? (wpx - bx) : (wpx + CW'(BUFFER_DEPTH) - bx);

        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        seen_next       = seen_reg;
        frozen_next     = frozen_reg;
        tag_time_next   = tag_time_reg;
        tag_pos_next    = tag_pos_reg;
        tag_period_next = tag_period_reg;

        q_push             = 1'b0;
        q_entry            = '0;
        q_entry.kind       = KIND_ECHO;
        q_entry.value      = s_data.sample_value;
        q_entry.error      = s_data.sample_error;
        q_entry.seen       = 64'(seen_reg);
        q_entry.tag_pos    = 64'(tag_pos_reg);
        q_entry.tag_time   = tag_time_reg;
        q_entry.tag_period = tag_period_reg;

        if (accept) begin
            case (s_data.command)
                CMD_SAMPLE: begin
                    q_push        = 1'b1;
                    q_entry.kind  = KIND_ECHO;
                    q_entry.wr_en = !frozen_reg;
                    q_entry.addr  = ADDR_BITS'(wp_reg);
                    if (!frozen_reg) begin
                        if (wp_reg == AW'(BUFFER_DEPTH - 1)) begin
                            wp_next      = '0;
                            wrapped_next = 1'b1;
                        end else begin
                            wp_next = wp_reg + AW'(1);
                        end
                        if (s_data.tag_present) begin
                            tag_time_next   = s_data.tag_timestamp;
                            tag_pos_next    = seen_reg;
                            tag_period_next = s_data.tag_period;
                        end
                    end
                    if (seen_reg != COUNT_MAX) begin
                        seen_next = seen_reg + COUNT_BITS'(1);
                    end
                end
                CMD_FREEZE: begin
                    frozen_next = 1'b1;
                end
                CMD_READ: begin
                    q_push          = 1'b1;
                    q_entry.kind    = in_win ? KIND_ENTRY : KIND_OUTSIDE;
                    q_entry.addr    = ADDR_BITS'(pos_x[AW-1:0]);
                    q_entry.rd_zero = !(wrapped_reg || no_wrap);
                    q_entry.n       = n;
                    if ((in_win && back_dist == LEN_BITS'(1)) || n == '0) begin
                        frozen_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sv/pmcr_queue.sv
// Short FIFO of ops between front end and back end.
module pmcr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pmcr_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output pmcr_pkg::q_entry_t head
);
    import pmcr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        full    = count_reg == NW'(QUEUE_DEPTH);
        valid   = count_reg != '0;
        head    = slot_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/pmcr_back.sv
// Back end: ring memory access and window timestamp pipeline with output register.
module pmcr_back #(
    parameter int BUFFER_DEPTH = pmcr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  pmcr_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output pmcr_pkg::out_item_t m_data
);
    import pmcr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef struct packed {
        kind_e               kind;
        logic [31:0]         value;
        logic [31:0]         error;
        logic                rd_zero;
        logic [LEN_BITS-1:0] n;
        logic [63:0]         tag_time;
        logic [31:0]         period;
        logic [63:0]         first;
        logic [63:0]         tag_pos;
    } st1_t;

    typedef struct packed {
        kind_e               kind;
        logic [31:0]         value;
        logic [31:0]         error;
        logic [LEN_BITS-1:0] n;
        logic [63:0]         tag_time;
        logic [31:0]         period;
        logic [63:0]         distance;
        logic                backward;
    } st2_t;

    typedef struct packed {
        kind_e               kind;
        logic [31:0]         value;
        logic [31:0]         error;
        logic [LEN_BITS-1:0] n;
        logic [63:0]         tag_time;
        logic [63:0]         p_lo;
        logic [63:0]         p_hi;
        logic                backward;
    } st3_t;

    typedef struct packed {
        kind_e               kind;
        logic [31:0]         value;
        logic [31:0]         error;
        logic [LEN_BITS-1:0] n;
        logic [63:0]         tag_time;
        logic [63:0]         delta;
        logic                backward;
    } st4_t;

    logic [31:0] value_mem [BUFFER_DEPTH];
    logic [31:0] error_mem [BUFFER_DEPTH];
    logic [31:0] rd_value_reg;
    logic [31:0] rd_error_reg;

    st1_t      st1_reg, st1_next;
    st2_t      st2_reg, st2_next;
    st3_t      st3_reg, st3_next;
    st4_t      st4_reg, st4_next;
    out_item_t out_reg, out_next;
    logic      v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    logic          advance;
    logic [AW-1:0] addr;
    logic [64:0]   diff;
    logic [31:0]   dist_lo;
    logic [31:0]   dist_hi;
    logic [63:0]   hi_part;
    logic [64:0]   delta_sum;
    logic [63:0]   fwd_sum;

    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && q_valid;
    assign addr    = q_head.addr[AW-1:0];
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_head.wr_en) begin
                value_mem[addr] <= q_head.value;
                error_mem[addr] <= q_head.error;
            end
            rd_value_reg <= value_mem[addr];
            rd_error_reg <= error_mem[addr];
        end
    end

    always_comb begin
        // stage 1: first sample count of the window
        st1_next          = '0;
        st1_next.kind     = q_head.kind;
        st1_next.value    = q_head.value;
        st1_next.error    = q_head.error;
        st1_next.rd_zero  = q_head.rd_zero;
        st1_next.n        = q_head.n;
        st1_next.tag_time = q_head.tag_time;
        st1_next.period   = q_head.tag_period;
        st1_next.first    = q_head.seen - 64'(q_head.n);
        st1_next.tag_pos  = q_head.tag_pos;

        // stage 2: payload select, distance to tag
        st2_next          = '0;
        st2_next.kind     = st1_reg.kind;
        st2_next.n        = st1_reg.n;
        st2_next.tag_time = st1_reg.tag_time;
        st2_next.period   = st1_reg.period;
        case (st1_reg.kind)
            KIND_ECHO: begin
                st2_next.value = st1_reg.value;
                st2_next.error = st1_reg.error;
            end
            KIND_ENTRY: begin
                st2_next.value = st1_reg.rd_zero ? '0 : rd_value_reg;
                st2_next.error = st1_reg.rd_zero ? '0 : rd_error_reg;
            end
            default: begin
                st2_next.value = '0;
                st2_next.error = '0;
            end
        endcase
        diff              = {1'b0, st1_reg.first} - {1'b0, st1_reg.tag_pos};
        st2_next.backward = diff[64];
        st2_next.distance = diff[64] ? (st1_reg.tag_pos - st1_reg.first) : diff[63:0];

        // stage 3: period times distance, two partial products
        dist_lo           = st2_reg.distance[31:0];
        dist_hi           = st2_reg.distance[63:32];
        st3_next          = '0;
        st3_next.kind     = st2_reg.kind;
        st3_next.value    = st2_reg.value;
        st3_next.error    = st2_reg.error;
        st3_next.n        = st2_reg.n;
        st3_next.tag_time = st2_reg.tag_time;
        st3_next.backward = st2_reg.backward;
        st3_next.p_lo     = 64'(st2_reg.period) * 64'(dist_lo);
        st3_next.p_hi     = 64'(st2_reg.period) * 64'(dist_hi);

        // stage 4: drop fraction bits, saturate
        hi_part           = {1'b0, st3_reg.p_hi[46:0], 16'b0};
        delta_sum         = 65'(hi_part) + 65'(st3_reg.p_lo[63:16]);
        st4_next          = '0;
        st4_next.kind     = st3_reg.kind;
        st4_next.value    = st3_reg.value;
        st4_next.error    = st3_reg.error;
        st4_next.n        = st3_reg.n;
        st4_next.tag_time = st3_reg.tag_time;
        st4_next.backward = st3_reg.backward;
        if (st3_reg.p_hi[63:47] != '0 || delta_sum[64] || delta_sum[63]) begin
            st4_next.delta = TS_MAX;
        end else begin
            st4_next.delta = delta_sum[63:0];
        end

        // stage 5: apply delta to held time
        fwd_sum            = st4_reg.tag_time + st4_reg.delta;
        out_next           = '0;
        out_next.kind      = st4_reg.kind;
        out_next.out_value = st4_reg.value;
        out_next.out_error = st4_reg.error;
        if (st4_reg.kind == KIND_ECHO) begin
            out_next.window_timestamp = TS_INVALID;
            out_next.window_length    = '0;
        end else begin
            out_next.window_length = st4_reg.n;
            if (st4_reg.tag_time[63]) begin
                out_next.window_timestamp = TS_INVALID;
            end else if (!st4_reg.backward) begin
                out_next.window_timestamp = fwd_sum[63] ? TS_MAX : fwd_sum;
            end else if (st4_reg.delta > st4_reg.tag_time) begin
                out_next.window_timestamp = '0;
            end else begin
                out_next.window_timestamp = st4_reg.tag_time - st4_reg.delta;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= q_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

endmodule

// File: sv/post_mortem_capture_ring.sv
// Top level of the post-mortem capture ring.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------
//  s_      | in  | s_valid / s_ready  | s_data  (pmcr_pkg::in_item_t)
//  m_      | out | m_valid / m_ready  | m_data  (pmcr_pkg::out_item_t)
//
// One transaction per cycle in and out while m_ready is high; the ring memory
// has one write and one read port, used by one op per cycle in the back end.
// A sample or read passes the queue, memory read, distance, multiply, saturate
// and output register stages before it shows at m_.
// Reset does not clear the ring: entries not yet written read as zero by a
// write-pointer/wrap check, so no clearing pass is needed.
// m_ready low holds the whole back end; the 2-entry queue lets s_ run on.
module post_mortem_capture_ring #(
    parameter int BUFFER_DEPTH = pmcr_pkg::BUFFER_DEPTH_DEF,
    parameter int COUNT_BITS   = pmcr_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmcr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pmcr_pkg::out_item_t m_data
);
    import pmcr_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_in;
    q_entry_t q_head;

    pmcr_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    pmcr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    pmcr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: sv/pmcr_checker.sv
// Port-level assertions for the post-mortem capture ring, bound to the top level.
module pmcr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input pmcr_pkg::out_item_t m_data
);
    import pmcr_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_ECHO |->
            m_data.window_timestamp == TS_INVALID && m_data.window_length == '0)
        else $error("sample echo carries window info");

    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_OUTSIDE |->
            m_data.out_value == '0 && m_data.out_error == '0)
        else $error("out-of-window read returned data");

    a_entry_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_ENTRY |-> m_data.window_length != '0)
        else $error("readout entry from empty window");

endmodule

bind post_mortem_capture_ring pmcr_checker u_pmcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/tb_post_mortem_capture_ring.sv
// Self-checking testbench for the post-mortem capture ring: predictor scoreboard plus random traffic.
`timescale 1ns / 1ps

import pmcr_pkg::*;

class ring_scoreboard;
    localparam int RING_DEPTH = BUFFER_DEPTH_DEF;
    localparam logic [63:0] SEEN_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;

    logic [31:0] value_mem [RING_DEPTH];
    logic [31:0] error_mem [RING_DEPTH];
    logic [63:0] wr_pos;
    logic [63:0] seen;
    bit          frozen;
    logic [63:0] held_time;
    logic [63:0] held_pos;
    logic [31:0] held_period;
    out_item_t   awaited_results[$];
    int          mismatches;

    function new();
        foreach (value_mem[i]) begin
            value_mem[i] = '0;
            error_mem[i] = '0;
        end
        wr_pos      = '0;
        seen        = '0;
        frozen      = 1'b0;
        held_time   = TS_INVALID;
        held_pos    = '0;
        held_period = '0;
        mismatches  = 0;
    endfunction

    // floor(period * distance / 2^16), saturated
    function logic [63:0] period_span(logic [31:0] period, logic [63:0] distance);
        logic [95:0] prod;
        prod = 96'(period) * 96'(distance);
        prod = prod >> 16;
        if (prod > 96'(TS_MAX)) return TS_MAX;
        return prod[63:0];
    endfunction

    function logic [63:0] window_start_time(logic [63:0] n);
        logic [63:0] first;
        logic [63:0] delta;
        if (held_time[63]) return TS_INVALID;
        first = seen - n;
        if (first >= held_pos) begin
            delta = period_span(held_period, first - held_pos);
            if (delta > TS_MAX - held_time) return TS_MAX;
            return held_time + delta;
        end
        delta = period_span(held_period, held_pos - first);
        if (delta > held_time) return '0;
        return held_time - delta;
    endfunction

    function void note_input(in_item_t it);
        out_item_t   r;
        logic [63:0] n;
        logic [63:0] idx;
        logic [63:0] slot;
        case (it.command)
            CMD_SAMPLE: begin
                if (!frozen) begin
                    value_mem[wr_pos] = it.sample_value;
                    error_mem[wr_pos] = it.sample_error;
                    if (it.tag_present) begin
                        held_time   = it.tag_timestamp;
                        held_pos    = seen;
                        held_period = it.tag_period;
                    end
                    wr_pos = (wr_pos + 64'd1) % RING_DEPTH;
                end
                if (seen < SEEN_MAX) seen = seen + 64'd1;
                r.kind             = KIND_ECHO;
                r.out_value        = it.sample_value;
                r.out_error        = it.sample_error;
                r.window_timestamp = TS_INVALID;
                r.window_length    = '0;
                awaited_results.push_back(r);
            end
            CMD_FREEZE: frozen = 1'b1;
            CMD_READ: begin
                n = 64'(it.read_count);
                if (n > seen) n = seen;
                if (n > RING_DEPTH) n = RING_DEPTH;
                idx = 64'(it.entry_index);
                r.window_timestamp = window_start_time(n);
                r.window_length    = n[LEN_BITS-1:0];
                if (idx < n) begin
                    slot = (wr_pos + RING_DEPTH - n + idx) % RING_DEPTH;
                    r.kind      = KIND_ENTRY;
                    r.out_value = value_mem[slot];
                    r.out_error = error_mem[slot];
                    if (idx == n - 64'd1) frozen = 1'b0;
                end else begin
                    r.kind      = KIND_OUTSIDE;
                    r.out_value = '0;
                    r.out_error = '0;
                    if (n == 0) frozen = 1'b0;
                end
                awaited_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void check_output(out_item_t got);
        out_item_t want;
        bit        bad;
        if (awaited_results.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: kind %0d value %h error %h ts %h len %0d",
                         got.kind, got.out_value, got.out_error,
                         got.window_timestamp, got.window_length);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        bad = (got.kind !== want.kind) || (got.out_value !== want.out_value)
            || (got.out_error !== want.out_error)
            || (got.window_timestamp !== want.window_timestamp)
            || (got.window_length !== want.window_length);
        if (bad) begin
            if (mismatches < 10) begin
                $display("mismatch: expected kind %0d value %h error %h ts %h len %0d",
                         want.kind, want.out_value, want.out_error,
                         want.window_timestamp, want.window_length);
                $display("          got      kind %0d value %h error %h ts %h len %0d",
                         got.kind, got.out_value, got.out_error,
                         got.window_timestamp, got.window_length);
            end
            mismatches++;
        end
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction
endclass

module tb_post_mortem_capture_ring;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 1050;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_CYCLES = 40;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    ring_scoreboard sb;
    bit  hold_req = 1'b0;
    bit  back_to_back = 1'b0;
    int  burst_left = 8;
    int  counted = 0;
    int  samples_offered = 0;

    post_mortem_capture_ring dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_output(m_data);
        end
    end

    function automatic in_item_t random_item();
        logic [191:0] raw;
        in_item_t     it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.read_count = LEN_BITS'($urandom_range(0, 1024));
        return it;
    endfunction

    function automatic in_item_t sample_item(logic [31:0] v, logic [31:0] e, logic tag,
                                             logic [63:0] ts, logic [31:0] per);
        in_item_t it;
        it = random_item();
        it.command       = CMD_SAMPLE;
        it.sample_value  = v;
        it.sample_error  = e;
        it.tag_present   = tag;
        it.tag_timestamp = ts;
        it.tag_period    = per;
        return it;
    endfunction

    function automatic in_item_t read_item(logic [LEN_BITS-1:0] n, logic [IDX_BITS-1:0] idx);
        in_item_t it;
        it = random_item();
        it.command     = CMD_READ;
        it.read_count  = n;
        it.entry_index = idx;
        return it;
    endfunction

    function automatic in_item_t bare_item(logic [1:0] cmd);
        in_item_t it;
        it = random_item();
        it.command = cmd;
        return it;
    endfunction

    function automatic logic [63:0] pick_timestamp();
        case ($urandom_range(0, 5))
            0: return TS_INVALID;
            1: return TS_MAX - 64'($urandom_range(0, 1000));
            2: return 64'($urandom_range(0, 1000));
            default: return {1'b0, 31'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF;
            1: return $urandom_range(0, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input in_item_t it);
        int gap;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.command != CMD_UNUSED) counted++;
        if (it.command == CMD_SAMPLE) samples_offered++;
        if (!back_to_back) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 8);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 48);
            end
        end
    endtask

    task automatic push_random_sample();
        logic tag;
        tag = ($urandom_range(0, 7) == 0);
        push_item(sample_item($urandom, $urandom, tag, pick_timestamp(), pick_period()));
    endtask

    task automatic push_random_read();
        int n;
        int avail;
        int idx;
        case ($urandom_range(0, 4))
            0: n = 1024;
            1: n = 0;
            2: n = $urandom_range(1, 16);
            default: n = $urandom_range(0, 1024);
        endcase
        avail = n;
        if (avail > samples_offered) avail = samples_offered;
        if (avail > 1024) avail = 1024;
        case ($urandom_range(0, 3))
            0: idx = (avail > 0) ? avail - 1 : $urandom_range(0, 1023);
            1: idx = (avail < 1024) ? $urandom_range(avail, 1023) : $urandom_range(0, 1023);
            default: idx = (avail > 0) ? $urandom_range(0, avail - 1) : $urandom_range(0, 1023);
        endcase
        push_item(read_item(n[LEN_BITS-1:0], idx[IDX_BITS-1:0]));
    endtask

    // receiver: segments in one of four random stall modes, plus one long hold-off on request
    initial begin
        int mode;
        int len;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 64);
            repeat (len) begin
                @(posedge aclk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_post_mortem_capture_ring: FAIL");
        $finish;
    end

    initial begin
        bit hold_done;
        int len;
        hold_done = 1'b0;
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty ring, frozen samples, unwritten entries
        push_item(read_item(11'd0, 10'd0));
        push_item(read_item(11'd1024, 10'd1023));
        push_item(bare_item(CMD_FREEZE));
        push_item(sample_item(32'hFFFF_FFFF, 32'h0, 1'b1, TS_MAX, 32'hFFFF_FFFF));
        push_item(read_item(11'd1024, 10'd0));
        // tag near max: forward saturation, backward subtraction
        push_item(sample_item(32'h0, 32'hFFFF_FFFF, 1'b1, TS_MAX - 64'd1, 32'h0001_0000));
        push_item(sample_item($urandom, $urandom, 1'b0, pick_timestamp(), $urandom));
        push_item(sample_item($urandom, $urandom, 1'b0, pick_timestamp(), $urandom));
        push_item(read_item(11'd1, 10'd0));
        push_item(read_item(11'd4, 10'd0));
        push_item(read_item(11'd4, 10'd2));
        push_item(bare_item(CMD_UNUSED));
        // small tag time: backward clamp to zero
        push_item(sample_item($urandom, $urandom, 1'b1, 64'd3, 32'hFFFF_FFFF));
        push_item(sample_item($urandom, $urandom, 1'b0, pick_timestamp(), $urandom));
        push_item(read_item(11'd6, 10'd0));
        push_item(sample_item($urandom, $urandom, 1'b1, TS_INVALID, $urandom));
        push_item(read_item(11'd3, 10'd1));
        push_item(bare_item(CMD_FREEZE));
        push_item(sample_item($urandom, $urandom, 1'b1, 64'd77, $urandom));
        push_item(sample_item($urandom, $urandom, 1'b0, pick_timestamp(), $urandom));
        push_item(read_item(11'd1024, 10'd1023));
        push_item(read_item(11'd0, 10'd5));
        push_item(sample_item($urandom, $urandom, 1'b0, pick_timestamp(), $urandom));
        push_item(read_item(11'd2, 10'd1));

        while (counted < ITEM_TARGET) begin
            if (!hold_done && counted >= 400) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                back_to_back = 1'b1;
                repeat (48) push_random_sample();
                back_to_back = 1'b0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    push_item(bare_item(CMD_FREEZE));
                    len = $urandom_range(0, 6);
                    repeat (len) push_random_sample();
                    len = $urandom_range(1, 4);
                    repeat (len) push_random_read();
                end
                3, 4, 5, 6: begin
                    len = $urandom_range(1, 6);
                    repeat (len) push_random_read();
                end
                7: push_item(bare_item($urandom_range(0, 1) ? CMD_UNUSED : CMD_FREEZE));
                default: begin
                    len = $urandom_range(1, 40);
                    repeat (len) push_random_sample();
                end
            endcase
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() == 0 && sb.mismatches == 0)
            $display("tb_post_mortem_capture_ring: PASS");
        else
            $display("tb_post_mortem_capture_ring: FAIL");
        $finish;
    end
endmodule
